FILE: rtl/bmpfb_pkg.sv
// shared types and constants for the bmp row to framebuffer writer
package bmpfb_pkg;

    localparam int BYTE_W     = 8;
    localparam int IMG_W_W    = 10;
    localparam int IMG_H_W    = 9;
    localparam int PIX_W      = 24;
    localparam int FB_ADDR_W  = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int M_FIELD_W  = FB_ADDR_W + PIX_W;
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_MODE  = 3'd4;

    localparam logic [1:0] PH_BLUE  = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_RED   = 2'd2;

    typedef struct packed {
        logic [IMG_W_W-1:0] image_width;
        logic [IMG_H_W-1:0] image_height;
        logic [IMG_W_W-1:0] left_offset;
        logic [IMG_H_W-1:0] top_offset;
        logic               center_mode;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        image_width:  10'd800,
        image_height: 9'd480,
        left_offset:  10'd0,
        top_offset:   9'd0,
        center_mode:  1'b0
    };

    typedef struct packed {
        logic [PIX_W-1:0] pixel_word;
        logic             last_pixel;
    } pix_t;

endpackage

FILE: rtl/bmpfb_unpack.sv
// byte sequencer: pixel assembly, padding drop, screen position and clipping
module bmpfb_unpack #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480,
    parameter int XUW = $clog2(SCREEN_WIDTH),
    parameter int YUW = $clog2(SCREEN_HEIGHT)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bmpfb_pkg::cfg_t             cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bmpfb_pkg::BYTE_W-1:0] in_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [XUW-1:0]              out_x,
    output logic [YUW-1:0]              out_y,
    output bmpfb_pkg::pix_t             out_pix
);

    localparam int XSW = ((XUW > bmpfb_pkg::IMG_W_W) ? XUW : bmpfb_pkg::IMG_W_W) + 2;
    localparam int YSW = ((YUW > bmpfb_pkg::IMG_H_W) ? YUW : bmpfb_pkg::IMG_H_W) + 2;
    localparam logic [XSW-1:0] SW_L   = XSW'(SCREEN_WIDTH);
    localparam logic [YSW-1:0] SH_L   = YSW'(SCREEN_HEIGHT);
    localparam logic [XSW-1:0] HALF_W = XSW'(SCREEN_WIDTH / 2);
    localparam logic [YSW-1:0] HALF_H = YSW'(SCREEN_HEIGHT / 2);

    logic [1:0]                        phase_reg, phase_next;
    logic [bmpfb_pkg::IMG_W_W-1:0]     col_reg, col_next;
    logic [bmpfb_pkg::IMG_H_W-1:0]     row_reg, row_next;
    logic [1:0]                        pad_reg, pad_next;
    logic [bmpfb_pkg::BYTE_W-1:0]      blue_reg, blue_next;
    logic [bmpfb_pkg::BYTE_W-1:0]      green_reg, green_next;
    logic                              a_valid_reg, a_valid_next;
    logic [XUW-1:0]                    a_x_reg;
    logic [YUW-1:0]                    a_y_reg;
    bmpfb_pkg::pix_t                   a_pix_reg;

    logic                              accept;
    logic                              zero_dim;
    logic                              in_pad;
    logic [1:0]                        npad;
    logic [1:0]                        pad_inc;
    logic [bmpfb_pkg::IMG_W_W-1:0]     col_inc;
    logic [bmpfb_pkg::IMG_H_W-1:0]     row_inc;
    logic                              end_row;
    logic                              emit;
    logic                              last;
    logic [XSW-1:0]                    x_off, x_pos;
    logic [YSW-1:0]                    y_off, y_pos;
    logic                              on_screen;

    assign accept   = in_valid && in_ready;
    assign in_ready = !a_valid_reg || out_ready;
    assign zero_dim = (cfg.image_width == '0) || (cfg.image_height == '0);
    assign in_pad   = col_reg >= cfg.image_width;
    // (4 - 3w mod 4) mod 4 reduces to w mod 4
    assign npad     = cfg.image_width[1:0];
    assign pad_inc  = pad_reg + 2'd1;
    assign col_inc  = col_reg + 10'd1;
    assign row_inc  = row_reg + 9'd1;
    assign last     = (row_reg == cfg.image_height - 9'd1)
                   && (col_reg == cfg.image_width - 10'd1);

    always_comb begin
        if (cfg.center_mode) begin
            x_off = HALF_W - XSW'(cfg.image_width >> 1);
            y_off = HALF_H - YSW'(cfg.image_height >> 1);
        end else begin
            x_off = XSW'(cfg.left_offset);
            y_off = YSW'(cfg.top_offset);
        end
    end

    assign x_pos = XSW'(col_reg) + x_off;
    assign y_pos = YSW'(cfg.image_height) - YSW'(1) - YSW'(row_reg) + y_off;
    assign on_screen = !x_pos[XSW-1] && (x_pos < SW_L)
                    && !y_pos[YSW-1] && (y_pos < SH_L);

    always_comb begin
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pad_next   = pad_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        end_row    = 1'b0;
        emit       = 1'b0;
        if (accept && !zero_dim) begin
            priority if (in_pad) begin
                pad_next = pad_inc;
                end_row  = pad_inc >= npad;
            end else if (phase_reg == bmpfb_pkg::PH_BLUE) begin
                blue_next  = in_byte;
                phase_next = bmpfb_pkg::PH_GREEN;
            end else if (phase_reg == bmpfb_pkg::PH_GREEN) begin
                green_next = in_byte;
                phase_next = bmpfb_pkg::PH_RED;
            end else begin
                phase_next = bmpfb_pkg::PH_BLUE;
                col_next   = col_inc;
                end_row    = (col_inc >= cfg.image_width) && (npad == 2'd0);
                emit       = on_screen;
            end
            if (end_row) begin
                col_next   = '0;
                pad_next   = '0;
                phase_next = bmpfb_pkg::PH_BLUE;
                row_next   = (row_inc >= cfg.image_height) ? '0 : row_inc;
            end
        end
    end

    always_comb begin
        if (accept) begin
            a_valid_next = emit;
        end else if (out_ready) begin
            a_valid_next = 1'b0;
        end else begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= bmpfb_pkg::PH_BLUE;
            col_reg     <= '0;
            row_reg     <= '0;
            pad_reg     <= '0;
            blue_reg    <= '0;
            green_reg   <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pad_reg     <= pad_next;
            blue_reg    <= blue_next;
            green_reg   <= green_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            a_x_reg              <= x_pos[XUW-1:0];
            a_y_reg              <= y_pos[YUW-1:0];
            a_pix_reg.pixel_word <= {in_byte, green_reg, blue_reg};
            a_pix_reg.last_pixel <= last;
        end
    end

    assign out_valid = a_valid_reg;
    assign out_x     = a_x_reg;
    assign out_y     = a_y_reg;
    assign out_pix   = a_pix_reg;

endmodule

FILE: rtl/bmp_rows_to_framebuffer_writer_unit.sv
// top level: config registers, byte sequencer and framebuffer address stage
//
//  channel  dir  handshake             payload
//  s_       in   s_tvalid/s_tready     s_tdata: data_byte
//  m_       out  m_tvalid/m_tready     m_tdata: fb_address, pixel_word; m_tlast: last_pixel
//  cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
//  one word per cycle while m_tready holds; a pixel write leaves after its red byte passes
//  through the sequencer register and then the address multiply register
//  reset clears counters, phase and valids; config returns to its defaults
//  a stalled m_ side backs up through both stages to s_tready
module bmp_rows_to_framebuffer_writer_unit #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bmpfb_pkg::BYTE_W-1:0]      s_tdata,    // [7:0] data_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bmpfb_pkg::M_TDATA_W-1:0]   m_tdata,    // [18:0] fb_address, [42:19] pixel_word
    output logic                              m_tlast,    // last_pixel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmpfb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmpfb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int XUW = $clog2(SCREEN_WIDTH);
    localparam int YUW = $clog2(SCREEN_HEIGHT);
    localparam int LW  = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
    localparam int PW  = (LW > bmpfb_pkg::FB_ADDR_W) ? LW : bmpfb_pkg::FB_ADDR_W;
    localparam int PAD_W = bmpfb_pkg::M_TDATA_W - bmpfb_pkg::M_FIELD_W;

    bmpfb_pkg::cfg_t                  cfg_reg, cfg_next;
    logic                             a_valid;
    logic                             a_ready;
    logic [XUW-1:0]                   a_x;
    logic [YUW-1:0]                   a_y;
    bmpfb_pkg::pix_t                  a_pix;
    logic [PW-1:0]                    addr_full;
    logic                             m_valid_reg, m_valid_next;
    logic [bmpfb_pkg::FB_ADDR_W-1:0]  m_addr_reg;
    bmpfb_pkg::pix_t                  m_pix_reg;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bmpfb_pkg::REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data;
                bmpfb_pkg::REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[8:0];
                bmpfb_pkg::REG_LEFT_OFFSET:  cfg_next.left_offset  = cfg_data;
                bmpfb_pkg::REG_TOP_OFFSET:   cfg_next.top_offset   = cfg_data[8:0];
                bmpfb_pkg::REG_CENTER_MODE:  cfg_next.center_mode  = cfg_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= bmpfb_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bmpfb_unpack #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .XUW           (XUW),
        .YUW           (YUW)
    ) u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_x     (a_x),
        .out_y     (a_y),
        .out_pix   (a_pix)
    );

    assign a_ready   = !m_valid_reg || m_tready;
    assign addr_full = PW'(a_y) * PW'(SCREEN_WIDTH) + PW'(a_x);

    always_comb begin
        if (a_valid && a_ready) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid && a_ready) begin
            m_addr_reg <= addr_full[bmpfb_pkg::FB_ADDR_W-1:0];
            m_pix_reg  <= a_pix;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {PAD_W'(0), m_pix_reg.pixel_word, m_addr_reg};
    assign m_tlast  = m_pix_reg.last_pixel;

endmodule

FILE: rtl/bmpfb_checker.sv
// port-level checks for the bmp row to framebuffer writer, with bind
module bmpfb_checker #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bmpfb_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                              m_tlast,
    input logic                              cfg_ready
);

    localparam int PW = bmpfb_pkg::M_TDATA_W;
    localparam logic [PW-1:0] FB_WORDS = PW'(SCREEN_WIDTH * SCREEN_HEIGHT);

    // stalled word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled word changed");

    // no word straight out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("word valid after reset");

    // address on screen and padding bits clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (PW'(m_tdata[bmpfb_pkg::FB_ADDR_W-1:0]) < FB_WORDS)
                 && (m_tdata[PW-1:bmpfb_pkg::M_FIELD_W] == '0))
        else $error("bad framebuffer address or padding");

    // checks that a newly held output still lets the input stage take one more byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!m_tvalid) && m_tvalid && !m_tready |-> s_tready)
        else $error("input stalled with free pipeline stage");

    // config port never blocks
    assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("config port not ready");

endmodule

bind bmp_rows_to_framebuffer_writer_unit bmpfb_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_bmpfb_checker (.*);

FILE: tb/bmp_rows_to_framebuffer_writer_unit_tb.sv
// testbench for the bmp row to framebuffer writer: directed and random byte streams checked against a predictor
module bmp_rows_to_framebuffer_writer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_W = 800;
    localparam int SCREEN_H = 480;
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic [bmpfb_pkg::FB_ADDR_W-1:0] fb_address;
        logic [bmpfb_pkg::PIX_W-1:0]     pixel_word;
        logic                            last_pixel;
    } fb_write_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [bmpfb_pkg::BYTE_W-1:0]     s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [bmpfb_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                             m_tlast;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [bmpfb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bmpfb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers and the byte sequencer
    bmpfb_pkg::cfg_t                  frame_cfg = bmpfb_pkg::CFG_RESET;
    logic [1:0]                       px_phase = bmpfb_pkg::PH_BLUE;
    logic [bmpfb_pkg::IMG_W_W-1:0]    px_col = '0;
    logic [bmpfb_pkg::IMG_H_W-1:0]    file_row = '0;
    logic [1:0]                       pad_seen = '0;
    logic [7:0]                       held_blue_q = '0;
    logic [7:0]                       held_green_q = '0;

    logic [bmpfb_pkg::BYTE_W-1:0] byte_queue[$];
    fb_write_t         fb_writes[$];
    int                bytes_queued = 0;
    int                bytes_accepted = 0;
    int                failures = 0;
    bit                no_gaps = 1'b0;
    int                hold_ticket = 0;
    int                hold_served = 0;
    int                gap_left = 0;
    int                stall_left = 0;

    bmp_rows_to_framebuffer_writer_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int pad_len(input logic [bmpfb_pkg::IMG_W_W-1:0] wd);
        int r;
        r = (int'(wd) * 3) & 3;
        return (r == 0) ? 0 : 4 - r;
    endfunction

    function automatic int idle_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void close_row();
        px_col = '0;
        pad_seen = '0;
        px_phase = bmpfb_pkg::PH_BLUE;
        file_row = file_row + 9'd1;
        if (file_row >= frame_cfg.image_height) file_row = '0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        int        npad, xoff, yoff, x, y;
        logic      last;
        fb_write_t wr;
        if (frame_cfg.image_width == '0 || frame_cfg.image_height == '0) return;
        npad = pad_len(frame_cfg.image_width);
        if (px_col >= frame_cfg.image_width) begin
            pad_seen = pad_seen + 2'd1;
            if (pad_seen >= npad) close_row();
            return;
        end
        if (px_phase == bmpfb_pkg::PH_BLUE) begin
            held_blue_q = b;
            px_phase = bmpfb_pkg::PH_GREEN;
            return;
        end
        if (px_phase == bmpfb_pkg::PH_GREEN) begin
            held_green_q = b;
            px_phase = bmpfb_pkg::PH_RED;
            return;
        end
        last = (int'(file_row) == int'(frame_cfg.image_height) - 1) &&
               (int'(px_col) == int'(frame_cfg.image_width) - 1);
        if (frame_cfg.center_mode) begin
            xoff = SCREEN_W / 2 - int'(frame_cfg.image_width) / 2;
            yoff = SCREEN_H / 2 - int'(frame_cfg.image_height) / 2;
        end else begin
            xoff = int'(frame_cfg.left_offset);
            yoff = int'(frame_cfg.top_offset);
        end
        x = int'(px_col) + xoff;
        y = int'(frame_cfg.image_height) - 1 - int'(file_row) + yoff;
        px_phase = bmpfb_pkg::PH_BLUE;
        px_col = px_col + 10'd1;
        if (px_col >= frame_cfg.image_width && npad == 0) close_row();
        if (x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H) return;
        wr.fb_address = bmpfb_pkg::FB_ADDR_W'(y * SCREEN_W + x);
        wr.pixel_word = {b, held_green_q, held_blue_q};
        wr.last_pixel = last;
        fb_writes.push_back(wr);
    endfunction

    // byte sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_byte(s_tdata);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= byte_queue.pop_front();
                    gap_left = idle_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // write receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (hold_served != hold_ticket) begin
            hold_served = hold_ticket;
            stall_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = idle_len();
            m_tready <= (stall_left == 0);
        end
    end

    always @(posedge aclk) begin : write_check
        fb_write_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (fb_writes.size() == 0) begin
                $error("unexpected framebuffer write: fb_address %0d pixel_word %06h",
                       m_tdata[bmpfb_pkg::FB_ADDR_W-1:0],
                       m_tdata[bmpfb_pkg::FB_ADDR_W +: bmpfb_pkg::PIX_W]);
                failures++;
            end else begin
                want = fb_writes.pop_front();
                if (m_tdata[bmpfb_pkg::FB_ADDR_W-1:0] !== want.fb_address) begin
                    $error("fb_address: expected %0d, got %0d",
                           want.fb_address, m_tdata[bmpfb_pkg::FB_ADDR_W-1:0]);
                    failures++;
                end
                if (m_tdata[bmpfb_pkg::FB_ADDR_W +: bmpfb_pkg::PIX_W] !== want.pixel_word) begin
                    $error("pixel_word: expected %06h, got %06h",
                           want.pixel_word, m_tdata[bmpfb_pkg::FB_ADDR_W +: bmpfb_pkg::PIX_W]);
                    failures++;
                end
                if (m_tlast !== want.last_pixel) begin
                    $error("last_pixel: expected %0b, got %0b", want.last_pixel, m_tlast);
                    failures++;
                end
            end
        end
    end

    task automatic write_reg(input logic [bmpfb_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= bmpfb_pkg::CFG_DATA_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            bmpfb_pkg::REG_IMAGE_WIDTH:
                frame_cfg.image_width = bmpfb_pkg::IMG_W_W'(value);
            bmpfb_pkg::REG_IMAGE_HEIGHT:
                frame_cfg.image_height = bmpfb_pkg::IMG_H_W'(value);
            bmpfb_pkg::REG_LEFT_OFFSET:
                frame_cfg.left_offset = bmpfb_pkg::IMG_W_W'(value);
            bmpfb_pkg::REG_TOP_OFFSET:
                frame_cfg.top_offset = bmpfb_pkg::IMG_H_W'(value);
            bmpfb_pkg::REG_CENTER_MODE:
                frame_cfg.center_mode = value[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(input int wd, input int ht, input int lf, input int tp,
                             input int ctr);
        write_reg(bmpfb_pkg::REG_IMAGE_WIDTH, wd);
        write_reg(bmpfb_pkg::REG_IMAGE_HEIGHT, ht);
        write_reg(bmpfb_pkg::REG_LEFT_OFFSET, lf);
        write_reg(bmpfb_pkg::REG_TOP_OFFSET, tp);
        write_reg(bmpfb_pkg::REG_CENTER_MODE, ctr);
    endtask

    task automatic push_byte(input logic [7:0] b);
        byte_queue.push_back(b);
        bytes_queued++;
    endtask

    // wait for every byte taken and every write seen
    task automatic settle();
        while (bytes_accepted != bytes_queued || fb_writes.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        int pick, wd, ht, lf, tp, ctr, nb;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one-pixel rows with a pad byte each, right screen edge, then image wrap
        set_frame(1, 2, 799, 0, 0);
        push_byte(8'h00); push_byte(8'h00); push_byte(8'h00); push_byte(8'hFF);
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hA5);
        push_byte(8'h55); push_byte(8'hAA); push_byte(8'h0F); push_byte(8'h3C);
        settle();

        // bottom-right corner, last two pixels run off the screen
        set_frame(4, 1, 798, 479, 0);
        push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
        push_byte(8'h12); push_byte(8'h34); push_byte(8'h56);
        push_byte(8'h80); push_byte(8'h7F); push_byte(8'h01);
        settle();

        // receiver holds off while the sender keeps going
        set_frame(8, 4, 0, 0, 0);
        hold_ticket++;
        repeat (192) push_byte(8'($urandom_range(0, 255)));
        settle();

        while (bytes_queued < 1850) begin
            pick = $urandom_range(0, 9);
            ctr = ($urandom_range(0, 3) == 0);
            if (pick == 0) begin
                wd = 800;
                ht = 480;
            end else if (pick == 1) begin
                wd = 1;
                ht = 1;
            end else if (pick == 2) begin
                wd = $urandom_range(9, 40);
                ht = $urandom_range(1, 3);
            end else begin
                wd = $urandom_range(1, 8);
                ht = $urandom_range(1, 6);
            end
            case ($urandom_range(0, 5))
                0: lf = 0;
                1: lf = 799;
                2: lf = $urandom_range(0, 799);
                default: lf = $urandom_range(0, 800 - wd);
            endcase
            case ($urandom_range(0, 5))
                0: tp = 0;
                1: tp = 479;
                2: tp = $urandom_range(0, 479);
                default: tp = $urandom_range(0, 480 - ht);
            endcase
            if (pick == 0) nb = $urandom_range(30, 150);
            else if ($urandom_range(0, 4) == 0) nb = $urandom_range(1, 60);
            else nb = ht * (3 * wd + pad_len(bmpfb_pkg::IMG_W_W'(wd))) * $urandom_range(1, 2);
            no_gaps = ($urandom_range(0, 4) == 0);
            set_frame(wd, ht, lf, tp, ctr);
            repeat (nb) push_byte(8'($urandom_range(0, 255)));
            settle();
        end

        settle();
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/bmpfb_pkg.sv
rtl/bmpfb_unpack.sv
rtl/bmp_rows_to_framebuffer_writer_unit.sv
rtl/bmpfb_checker.sv
tb/bmp_rows_to_framebuffer_writer_unit_tb.sv
